/* design/flaf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the flux-limited advection flux block.
// No dependencies.
package flaf_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int FACE_W    = $clog2(MAX_CELLS + 1);
  localparam int MAG_W     = 62;
  localparam int CAP_W     = 63;

  localparam logic [1:0] LIM_SUPERBEE = 2'd0;
  localparam logic [1:0] LIM_UPWIND   = 2'd1;
  localparam logic [1:0] LIM_LAXWEN   = 2'd2;
  localparam logic [1:0] LIM_BEAMWARM = 2'd3;

  localparam logic [1:0] REG_INLET     = 2'd0;
  localparam logic [1:0] REG_TIME_STEP = 2'd1;
  localparam logic [1:0] REG_LIMITER   = 2'd2;
  localparam logic [1:0] REG_FLAT_THR  = 2'd3;

  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << 61;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic [30:0] time_step;
    logic [1:0]  limiter_mode;
    logic [15:0] flat_threshold;
  } cfg_t;

  // One cell's worth of work for the arithmetic side.
  typedef struct packed {
    logic               start;
    logic               last;
    logic signed [31:0] t;
    logic signed [31:0] tup;
    logic signed [32:0] dup;
    logic signed [32:0] dif;
    logic signed [31:0] v;
    logic [30:0]        rho;
    logic [30:0]        cp;
    logic [30:0]        len;
    logic [FACE_W-1:0]  idx0;
    logic [FACE_W-1:0]  idx1;
  } job_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [MAG_W-1:0] mag63(input logic signed [CAP_W-1:0] v);
    logic [CAP_W-1:0] m;
    m = v[CAP_W-1] ? CAP_W'(-v) : CAP_W'(v);
    mag63 = m[MAG_W-1:0];
  endfunction

  function automatic logic signed [32:0] limit_phi(input logic signed [31:0] th,
                                                   input logic [1:0] mode);
    logic signed [33:0] th2, a, b, p;
    th2 = 34'(th) <<< 1;
    a = (th2 < 34'sd65536) ? th2 : 34'sd65536;
    b = (34'(th) < 34'sd131072) ? 34'(th) : 34'sd131072;
    p = (a > b) ? a : b;
    unique case (mode)
      LIM_SUPERBEE: limit_phi = (p > 34'sd0) ? 33'(p) : 33'sd0;
      LIM_UPWIND:   limit_phi = 33'sd0;
      LIM_LAXWEN:   limit_phi = 33'(ONE_Q16);
      LIM_BEAMWARM: limit_phi = 33'(th);
    endcase
  endfunction

  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      sat48 = 48'h7FFF_FFFF_FFFF;
    end else if (v < -64'sh0000_8000_0000_0000) begin
      sat48 = 48'h8000_0000_0000;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

endpackage

/* design/flaf_if.sv */
`timescale 1ns / 1ps
// Cell and face channels with valid/ready handshake.
// No dependencies.
interface flaf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_temperature;
  logic signed [31:0] flow_velocity;
  logic [30:0]        cell_density;
  logic [30:0]        specific_heat;
  logic [30:0]        cell_length;
  logic               last_cell;

  modport source(output valid, cell_temperature, flow_velocity, cell_density,
                 specific_heat, cell_length, last_cell, input ready);
  modport sink(input valid, cell_temperature, flow_velocity, cell_density,
               specific_heat, cell_length, last_cell, output ready);
endinterface

interface flaf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] face_flux;
  logic [10:0]        face_index;
  logic               last_face;

  modport source(output valid, face_flux, face_index, last_face, input ready);
  modport sink(input valid, face_flux, face_index, last_face, output ready);
endinterface

/* design/flaf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts cells, tracks column position and temperatures, builds jobs.
// Depends on flaf_pkg and flaf_in_if.
module flaf_front (
  input  logic                clk,
  input  logic                rst_n,
  flaf_in_if.sink             in_ch,
  input  logic signed [31:0]  inlet_temperature,
  output flaf_pkg::job_t      job,
  output logic                job_valid,
  input  logic                job_ready
);
  import flaf_pkg::*;

  logic signed [31:0] prior_t_r, older_t_r;
  logic [FACE_W-1:0]  fc_r;
  logic               start_r;
  logic [FACE_W-1:0]  idx0, n1;
  logic               accept;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign accept      = in_ch.valid & job_ready;

  always_comb begin
    idx0 = start_r ? '0 : fc_r;
    n1   = (idx0 < FACE_W'(MAX_CELLS)) ? idx0 + FACE_W'(1) : idx0;
    job.start = start_r;
    job.last  = in_ch.last_cell;
    job.t     = in_ch.cell_temperature;
    job.tup   = start_r ? inlet_temperature : prior_t_r;
    job.dup   = start_r ? 33'sd0 : 33'(prior_t_r) - 33'(older_t_r);
    job.dif   = 33'(in_ch.cell_temperature) - 33'(job.tup);
    job.v     = in_ch.flow_velocity;
    job.rho   = in_ch.cell_density;
    job.cp    = in_ch.specific_heat;
    job.len   = in_ch.cell_length;
    job.idx0  = idx0;
    job.idx1  = n1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_t_r <= '0;
      older_t_r <= '0;
      fc_r      <= '0;
      start_r   <= 1'b1;
    end else if (accept) begin
      older_t_r <= job.tup;
      prior_t_r <= in_ch.cell_temperature;
      fc_r      <= in_ch.last_cell ? '0 : n1;
      start_r   <= in_ch.last_cell;
    end
  end

endmodule

/* design/flaf_queue.sv */
`timescale 1ns / 1ps
// Two-entry job queue between front and back ends.
// Depends on flaf_pkg.
module flaf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  flaf_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output flaf_pkg::job_t rd_data
);
  import flaf_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/flaf_mulq.sv */
`timescale 1ns / 1ps
// Multi-cycle Q.16 magnitude multiplier: four 32x32 partials, rounding, saturation.
// Depends on flaf_pkg.
module flaf_mulq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [flaf_pkg::MAG_W-1:0] a,
  input  logic [flaf_pkg::MAG_W-1:0] b,
  output logic                       done,
  output logic [flaf_pkg::MAG_W-1:0] y
);
  import flaf_pkg::*;

  logic [MAG_W-1:0] a_r, b_r, y_r;
  logic [123:0]     acc_r;
  logic [63:0]      pp_r;
  logic [1:0]       sh_r;
  logic [2:0]       cnt_r;
  logic             busy_r, done_r;
  logic [31:0]      ma, mb;
  logic [61:0]      rnd;

  assign done = done_r;
  assign y    = y_r;

  always_comb begin
    ma  = cnt_r[1] ? {2'b0, a_r[61:32]} : a_r[31:0];
    mb  = cnt_r[0] ? {2'b0, b_r[61:32]} : b_r[31:0];
    rnd = acc_r[76:16] + 62'(acc_r[15]);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r && cnt_r < 3'd4) begin
      pp_r <= 64'(ma) * 64'(mb);
      sh_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
    end
    if (start) begin
      acc_r <= '0;
    end else if (busy_r && cnt_r != 3'd0 && cnt_r != 3'd5) begin
      acc_r <= acc_r + ({60'b0, pp_r} << {sh_r, 5'b0});
    end
    if (busy_r && cnt_r == 3'd5) begin
      if (|acc_r[123:77] || rnd > MAG_CAP) y_r <= MAG_CAP;
      else y_r <= rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

endmodule

/* design/flaf_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider: floor(x * 2^16 / d) to 32 bits, flags overflow.
// Depends on flaf_pkg.
module flaf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [flaf_pkg::MAG_W-1:0] x,
  input  logic [32:0]                d,
  output logic                       done,
  output logic [31:0]                q,
  output logic                       ovf
);
  import flaf_pkg::*;

  logic [32:0] d_r, rem_r;
  logic [31:0] lo_r, q_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r, ovf_r;
  logic [33:0] trial;
  logic        qbit;

  assign done  = done_r;
  assign q     = q_r;
  assign ovf   = ovf_r;
  assign trial = {rem_r, lo_r[31]};
  assign qbit  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= d;
      rem_r <= x[48:16];
      lo_r  <= {x[15:0], 16'b0};
      ovf_r <= (x[61:16] >= {13'b0, d});
    end else if (busy_r) begin
      rem_r <= qbit ? 33'(trial - {1'b0, d_r}) : trial[32:0];
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[30:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (x[61:16] >= {13'b0, d}) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/flaf_back.sv */
`timescale 1ns / 1ps
// Back end: sequences the shared multiplier and divider over each job, drives results.
// Depends on flaf_pkg, flaf_out_if, flaf_mulq and flaf_div.
module flaf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  flaf_pkg::cfg_t cfg,
  input  logic           job_valid,
  output logic           job_ready,
  input  flaf_pkg::job_t job,
  flaf_out_if.source     out_ch
);
  import flaf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CAP1  = 4'd1;
  localparam logic [3:0] ST_CAP2  = 4'd2;
  localparam logic [3:0] ST_UP    = 4'd3;
  localparam logic [3:0] ST_PROD  = 4'd4;
  localparam logic [3:0] ST_CDIV  = 4'd5;
  localparam logic [3:0] ST_THETA = 4'd6;
  localparam logic [3:0] ST_DM    = 4'd7;
  localparam logic [3:0] ST_K     = 4'd8;
  localparam logic [3:0] ST_M     = 4'd9;
  localparam logic [3:0] ST_EMIT0 = 4'd10;
  localparam logic [3:0] ST_OUTUP = 4'd11;
  localparam logic [3:0] ST_EMIT1 = 4'd12;

  logic [3:0]               state_r, state_nxt;
  logic                     go_r;
  job_t                     job_r;
  logic [MAG_W-1:0]         x_r, p_r, dm_r, k_r, m_r;
  logic signed [CAP_W-1:0]  capn_r, capp_r, up_r;
  logic [30:0]              lenp_r;
  logic signed [33:0]       f_r;
  logic signed [31:0]       theta_r;
  logic                     dneg_r;

  logic                     out_valid_r, out_last_r;
  logic [47:0]              out_flux_r;
  logic [FACE_W-1:0]        out_idx_r;

  logic signed [CAP_W-1:0]  capf;
  logic [MAG_W-1:0]         capf_m, mul_a, mul_b, mul_y, div_x, fixm;
  logic [30:0]              lenf_raw, lenf;
  logic [32:0]              difm, dupm, div_d;
  logic                     flat, is_mul, is_div, mul_done, div_done, div_ovf;
  logic [31:0]              div_q, qneg;
  logic signed [32:0]       phi;
  logic signed [63:0]       fix, sum;
  logic [32:0]              cval;
  logic                     out_free, tneg;
  logic signed [CAP_W-1:0]  ysig;

  assign job_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    capf     = job_r.start ? capn_r : capp_r;
    capf_m   = mag63(capf);
    lenf_raw = job_r.start ? job_r.len : lenp_r;
    lenf     = (lenf_raw == '0) ? 31'd1 : lenf_raw;
    difm     = mag33(job_r.dif);
    dupm     = mag33(job_r.dup);
    flat     = (difm == '0) || (difm < {17'b0, cfg.flat_threshold});
    phi      = limit_phi(theta_r, cfg.limiter_mode);
    ysig     = $signed({1'b0, mul_y});
    qneg     = 32'(-div_q);
    cval     = div_ovf ? 33'h1_0000_0000 : {1'b0, div_q};
    fixm     = {1'b0, m_r[61:1]} + MAG_W'(m_r[0]);
    fix      = (f_r[33] ^ dneg_r) ? -64'($signed({1'b0, fixm})) : 64'($signed({1'b0, fixm}));
    sum      = 64'(up_r) + fix;
    tneg     = (capf < 0) ^ job_r.tup[31];
  end

  // Operand steering for the shared multiplier and divider.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_CAP1:  begin mul_a = MAG_W'(mag32(job_r.v)); mul_b = MAG_W'(job_r.rho); end
      ST_CAP2:  begin mul_a = x_r;    mul_b = MAG_W'(job_r.cp); end
      ST_UP:    begin mul_a = capf_m; mul_b = MAG_W'(mag32(job_r.tup)); end
      ST_PROD:  begin mul_a = capf_m; mul_b = MAG_W'(cfg.time_step); end
      ST_DM:    begin mul_a = MAG_W'(mag33(phi)); mul_b = MAG_W'(difm); end
      ST_K:     begin mul_a = capf_m; mul_b = MAG_W'(f_r[33] ? 34'(-f_r) : 34'(f_r)); end
      ST_M:     begin mul_a = k_r;    mul_b = dm_r; end
      ST_OUTUP: begin mul_a = mag63(capn_r); mul_b = MAG_W'(mag32(job_r.t)); end
      default:  begin mul_a = '0;     mul_b = '0; end
    endcase
    is_mul = (state_r == ST_CAP1) || (state_r == ST_CAP2) || (state_r == ST_UP) ||
             (state_r == ST_PROD) || (state_r == ST_DM) || (state_r == ST_K) ||
             (state_r == ST_M) || (state_r == ST_OUTUP);
    is_div = (state_r == ST_CDIV) || (state_r == ST_THETA && !flat);
    div_x  = (state_r == ST_CDIV) ? p_r : MAG_W'(dupm);
    div_d  = (state_r == ST_CDIV) ? {2'b0, lenf} : difm;
  end

  flaf_mulq u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r && is_mul),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .y     (mul_y)
  );

  flaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r && is_div),
    .x     (div_x),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q),
    .ovf   (div_ovf)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = ST_CAP1;
      ST_CAP1:  if (mul_done) state_nxt = ST_CAP2;
      ST_CAP2:  if (mul_done) state_nxt = ST_UP;
      ST_UP:    if (mul_done) state_nxt = ST_PROD;
      ST_PROD:  if (mul_done) state_nxt = ST_CDIV;
      ST_CDIV:  if (div_done) state_nxt = ST_THETA;
      ST_THETA: if (div_done || (go_r && flat)) state_nxt = ST_DM;
      ST_DM:    if (mul_done) state_nxt = ST_K;
      ST_K:     if (mul_done) state_nxt = ST_M;
      ST_M:     if (mul_done) state_nxt = ST_EMIT0;
      ST_EMIT0: if (out_free) state_nxt = job_r.last ? ST_OUTUP : ST_IDLE;
      ST_OUTUP: if (mul_done) state_nxt = ST_EMIT1;
      ST_EMIT1: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid) job_r <= job;
    if (mul_done) begin
      unique case (state_r)
        ST_CAP1:  x_r <= mul_y;
        ST_CAP2:  capn_r <= job_r.v[31] ? -ysig : ysig;
        ST_UP:    up_r <= tneg ? -ysig : ysig;
        ST_PROD:  p_r <= mul_y;
        ST_DM:    dm_r <= mul_y;
        ST_K:     k_r <= mul_y;
        ST_M:     m_r <= mul_y;
        ST_OUTUP: up_r <= ((capn_r < 0) ^ job_r.t[31]) ? -ysig : ysig;
        default:  x_r <= x_r;
      endcase
    end
    if (state_r == ST_DM) dneg_r <= phi[32] ^ job_r.dif[32];
    if (div_done && state_r == ST_CDIV) f_r <= 34'sd65536 - $signed({1'b0, cval});
    if (state_r == ST_THETA) begin
      if (go_r && flat) begin
        theta_r <= ONE_Q16;
      end else if (div_done) begin
        // Saturate to the signed 32-bit range; the sign follows both jumps.
        if (job_r.dup[32] ^ job_r.dif[32]) begin
          theta_r <= (div_ovf || div_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(qneg);
        end else begin
          theta_r <= (div_ovf || div_q[31]) ? 32'sh7FFF_FFFF : $signed(div_q);
        end
      end
    end
    if (state_r == ST_EMIT0 && out_free) begin
      out_flux_r <= sat48(sum);
      out_idx_r  <= job_r.idx0;
      out_last_r <= 1'b0;
    end else if (state_r == ST_EMIT1 && out_free) begin
      out_flux_r <= sat48(64'(up_r));
      out_idx_r  <= job_r.idx1;
      out_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      capp_r      <= '0;
      lenp_r      <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_nxt != state_r);
      if ((state_r == ST_EMIT0 || state_r == ST_EMIT1) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_EMIT0 && out_free) begin
        capp_r <= capn_r;
        lenp_r <= job_r.len;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.face_flux  = $signed(out_flux_r);
  assign out_ch.face_index = out_idx_r;
  assign out_ch.last_face  = out_last_r;

endmodule

/* design/flux_limited_advection_flux.sv */
`timescale 1ns / 1ps
// Top level of the flux-limited advection flux block: configuration registers,
// front end, job queue and back end. Depends on flaf_pkg, flaf_if and all flaf_ modules.
//
// Cells of one flow column enter in flow order on in_ch; for each cell the block
// returns the flux through the cell's upstream face on out_ch, and for a cell marked
// last_cell also the outlet face (correction zero), after which the next cell opens
// a new column at face 0 using the inlet temperature. Each face is the upwind flux
// C*Tup plus a limited correction, where C = velocity*density*specific heat and the
// limiter (superbee, upwind, Lax-Wendroff or beam-warming) acts on theta, the ratio
// of the upstream to the local temperature jump; theta is one on a flat interface.
// Results are signed Q32.16, saturated. The back end runs every product through one
// shared multiplier that builds each result from four 32x32 partials, and the Courant
// number and theta through one restoring divider that, unless it flags overflow,
// yields its 32-bit quotient one bit per cycle. A two-entry queue lets up to two
// further cells be taken while a cell is computed, and the output register lets the
// back end go on while a finished face waits to be taken.
// Configuration writes over the APB-style port are meant for idle periods only.
module flux_limited_advection_flux (
  input  logic        clk,
  input  logic        rst_n,
  flaf_in_if.sink     in_ch,
  flaf_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import flaf_pkg::*;

  logic signed [31:0] inlet_r;
  cfg_t               cfg_r;
  logic               cfg_wr;
  job_t               fe_job, q_job;
  logic               fe_valid, fe_ready, q_valid, q_ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  // Register file: one word per register, decoded on the word address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inlet_r              <= '0;
      cfg_r.time_step      <= 31'd65536;
      cfg_r.limiter_mode   <= LIM_SUPERBEE;
      cfg_r.flat_threshold <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_INLET:     inlet_r              <= cfg_pwdata;
        REG_TIME_STEP: cfg_r.time_step      <= cfg_pwdata[30:0];
        REG_LIMITER:   cfg_r.limiter_mode   <= cfg_pwdata[1:0];
        REG_FLAT_THR:  cfg_r.flat_threshold <= cfg_pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_INLET:     cfg_prdata = inlet_r;
      REG_TIME_STEP: cfg_prdata = {1'b0, cfg_r.time_step};
      REG_LIMITER:   cfg_prdata = {30'b0, cfg_r.limiter_mode};
      REG_FLAT_THR:  cfg_prdata = {16'b0, cfg_r.flat_threshold};
    endcase
  end

  // Front end: classify each cell and hand a self-contained job to the queue.
  flaf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .inlet_temperature (inlet_r),
    .job               (fe_job),
    .job_valid         (fe_valid),
    .job_ready         (fe_ready)
  );

  // Hold jobs so the front keeps taking cells while the back end computes.
  flaf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_job)
  );

  // Back end: compute and drive one or two faces per job.
  flaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_ch    (out_ch)
  );

endmodule
